// ===== hdl/assert_macros.svh =====
// Assertion macros used by the slot allocator sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define FFCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising clk edge outside reset.
`define FFCA_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check a next-cycle implication on every rising clk edge outside reset.
`define FFCA_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/ffca_pkg.sv =====
// Shared constants, codes and types of the first-fit slot allocator.
`default_nettype none

package ffca_pkg;

    localparam int SLOTS    = 1024;
    localparam int TAG_BITS = 16;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int CMD_W    = 2;
    localparam int PLATE_W  = 16;
    localparam int LOT_W    = 11;
    localparam int STATUS_W = 3;
    localparam int START_W  = 10;

    localparam logic [LOT_W-1:0] LOT_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/ffca_if.sv =====
// Handshake channel interfaces of the slot allocator.
`default_nettype none

interface ffca_req_if;
    logic                              valid;
    logic                              ready;
    logic [ffca_pkg::CMD_W-1:0]        cmd;
    logic [ffca_pkg::PLATE_W-1:0]      plate;
    logic [ffca_pkg::LOT_W-1:0]        car_length;

    modport source (output valid, cmd, plate, car_length, input ready);
    modport sink   (input valid, cmd, plate, car_length, output ready);
endinterface

interface ffca_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ffca_pkg::STATUS_W-1:0]     status;
    logic [ffca_pkg::START_W-1:0]      start_slot;

    modport source (output valid, status, start_slot, input ready);
    modport sink   (input valid, status, start_slot, output ready);
endinterface

interface ffca_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ffca_pkg::LOT_W-1:0]        lot_length;

    modport source (output valid, lot_length, input ready);
    modport sink   (input valid, lot_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/ffca_cell.sv =====
// Owner ring slot: holds a tag; shift loads the neighbor's tag, clear zeroes it.
`default_nettype none

module ffca_cell (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ffca_pkg::ring_ctrl_t             ctl,
    input  wire logic [ffca_pkg::TAG_BITS-1:0]    d,
    output logic      [ffca_pkg::TAG_BITS-1:0]    q
);

    logic [ffca_pkg::TAG_BITS-1:0] owner_reg;
    logic [ffca_pkg::TAG_BITS-1:0] owner_next;

    always_comb
    begin
        owner_next = owner_reg;
        if (ctl.clear)
        begin
            owner_next = '0;
        end
        else if (ctl.shift)
        begin
            owner_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
        end
        else
        begin
            owner_reg <= owner_next;
        end
    end

    assign q = owner_reg;

endmodule

`default_nettype wire

// ===== hdl/ffca_ctrl.sv =====
// Request sequencer: search pass and fill pass over the ring head, result register.
`default_nettype none

`include "assert_macros.svh"

module ffca_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [ffca_pkg::LOT_W-1:0]       lot_length,
    input  wire logic [ffca_pkg::TAG_BITS-1:0]    head,
    output logic      [ffca_pkg::TAG_BITS-1:0]    wb,
    output ffca_pkg::ring_ctrl_t                  ring,
    ffca_req_if.sink                              req,
    ffca_rsp_if.source                            rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ffca_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                            alloc_reg, alloc_next;
    logic [ffca_pkg::TAG_BITS-1:0]   tag_reg, tag_next;
    logic [ffca_pkg::LOT_W-1:0]      want_reg, want_next;
    logic                            present_reg, present_next;
    logic                            found_reg, found_next;
    logic [ffca_pkg::CNT_W-1:0]      run_reg, run_next;
    logic [ffca_pkg::IDX_W-1:0]      start_reg, start_next;
    ffca_pkg::status_t               res_reg, res_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    ffca_pkg::status_t               status_reg, status_next;
    logic [ffca_pkg::START_W-1:0]    start_slot_reg, start_slot_next;

    logic [ffca_pkg::CNT_W-1:0]      used_len;
    logic                            in_lot;
    logic                            last;
    logic                            in_run;

    always_comb
    begin
        if (32'(lot_length) > 32'(ffca_pkg::SLOTS))
        begin
            used_len = ffca_pkg::CNT_W'(ffca_pkg::SLOTS);
        end
        else
        begin
            used_len = ffca_pkg::CNT_W'(lot_length);
        end
    end

    assign in_lot = ffca_pkg::CNT_W'(idx_reg) < used_len;
    assign last   = idx_reg == ffca_pkg::IDX_W'(ffca_pkg::SLOTS - 1);
    assign in_run = (idx_reg >= start_reg)
                 && (32'(idx_reg) < 32'(start_reg) + 32'(want_reg));

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        alloc_next      = alloc_reg;
        tag_next        = tag_reg;
        want_next       = want_reg;
        present_next    = present_reg;
        found_next      = found_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg;
        status_next     = status_reg;
        start_slot_next = start_slot_reg;
        ring            = '0;
        wb              = head;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    alloc_next = (req.cmd == ffca_pkg::CMD_ALLOC);
                    tag_next   = ffca_pkg::TAG_BITS'(req.plate);
                    want_next  = req.car_length;
                    if (req.cmd[1])
                    begin
                        ring.clear = 1'b1;
                        res_next   = ffca_pkg::ST_CLEARED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next     = '0;
                        present_next = 1'b0;
                        found_next   = 1'b0;
                        run_next     = '0;
                        start_next   = '0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ring.shift = 1'b1;
                idx_next   = last ? '0 : idx_reg + 1'b1;
                if (in_lot)
                begin
                    if (head == tag_reg)
                    begin
                        present_next = 1'b1;
                    end
                    if (!found_reg)
                    begin
                        if (head == '0)
                        begin
                            run_next = run_reg + 1'b1;
                            if (32'(run_reg) + 32'd1 == 32'(want_reg))
                            begin
                                found_next = 1'b1;
                                start_next = ffca_pkg::IDX_W'(32'(idx_reg) + 32'd1
                                                              - 32'(want_reg));
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end
                    end
                end
                if (last)
                begin
                    state_next = S_DONE;
                    if (alloc_reg)
                    begin
                        if (tag_reg == '0 || present_next)
                        begin
                            res_next = ffca_pkg::ST_PRESENT;
                        end
                        else if (!found_next)
                        begin
                            res_next = ffca_pkg::ST_NO_ROOM;
                        end
                        else
                        begin
                            state_next = S_FILL;
                        end
                    end
                    else
                    begin
                        if (tag_reg == '0 || !present_next)
                        begin
                            res_next = ffca_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            state_next = S_FILL;
                        end
                    end
                end
            end
            S_FILL:
            begin
                ring.shift = 1'b1;
                idx_next   = last ? '0 : idx_reg + 1'b1;
                if (alloc_reg)
                begin
                    if (in_lot && in_run)
                    begin
                        wb = tag_reg;
                    end
                end
                else if (in_lot && head == tag_reg)
                begin
                    wb = '0;
                end
                if (last)
                begin
                    res_next   = alloc_reg ? ffca_pkg::ST_ALLOCATED : ffca_pkg::ST_RELEASED;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    status_next     = res_reg;
                    start_slot_next = (res_reg == ffca_pkg::ST_ALLOCATED)
                                    ? ffca_pkg::START_W'(start_reg) : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        alloc_reg      <= alloc_next;
        tag_reg        <= tag_next;
        want_reg       <= want_next;
        present_reg    <= present_next;
        found_reg      <= found_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        start_slot_reg <= start_slot_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.start_slot = start_slot_reg;

    `FFCA_ASSERT_IMP(a_shift_in_pass, ring.shift,
        state_reg == S_SCAN || state_reg == S_FILL, "ring shifts outside a pass")
    `FFCA_ASSERT_IMP(a_pass_full_turn,
        (state_reg == S_SCAN || state_reg == S_FILL) && state_next != state_reg,
        last, "pass ends before a full ring turn")
    `FFCA_ASSERT_IMP(a_start_only_alloc,
        rsp_valid_reg && status_reg != ffca_pkg::ST_ALLOCATED,
        start_slot_reg == '0, "nonzero start slot on a non-allocation result")
    `FFCA_ASSERT_NXT(a_accept_busy, req.valid && req.ready,
        state_reg != S_IDLE, "sequencer idle after accepting a request")

endmodule

`default_nettype wire

// ===== hdl/first_fit_contiguous_slot_allocator_unit.sv =====
// A request (allocate, release by tag, clear) is answered with one result beat. Allocate and
// release make two turns between accept and result: the owner tags sit in a ring of SLOTS
// cells that rotates one slot per cycle past a single head, once to search (tag presence
// and first free run) and once to write tags or free slots. A rejected allocate or an
// absent release stops after the search turn; clear makes no turn. One request is in
// flight at a time; a finished result waits in the output register while the next request
// is taken. Write lot_length on the cfg channel only while idle; the unit does not check.
`default_nettype none

module first_fit_contiguous_slot_allocator_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ffca_req_if.sink       req,
    ffca_rsp_if.source     rsp,
    ffca_cfg_if.sink       cfg
);

    logic [ffca_pkg::LOT_W-1:0]       lot_reg, lot_next;
    ffca_pkg::ring_ctrl_t             ring;
    logic [ffca_pkg::TAG_BITS-1:0]    wb;
    logic [ffca_pkg::TAG_BITS-1:0]    owner [ffca_pkg::SLOTS];

    assign cfg.ready = 1'b1;

    always_comb
    begin
        lot_next = lot_reg;
        if (cfg.valid)
        begin
            lot_next = cfg.lot_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lot_reg <= ffca_pkg::LOT_RESET;
        end
        else
        begin
            lot_reg <= lot_next;
        end
    end

    for (genvar i = 0; i < ffca_pkg::SLOTS; i++)
    begin : g_ring
        logic [ffca_pkg::TAG_BITS-1:0] d;
        if (i == ffca_pkg::SLOTS - 1)
        begin : g_tail
            assign d = wb;
        end
        else
        begin : g_body
            assign d = owner[i + 1];
        end
        ffca_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ring),
            .d     (d),
            .q     (owner[i])
        );
    end

    ffca_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .lot_length (lot_reg),
        .head       (owner[0]),
        .wb         (wb),
        .ring       (ring),
        .req        (req),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/first_fit_contiguous_slot_allocator_unit_test.sv =====
// Self-checking testbench of the first-fit contiguous slot allocator unit.
`timescale 1ns / 1ps

module first_fit_contiguous_slot_allocator_unit_test;

    import ffca_pkg::*;

    localparam logic [CMD_W-1:0] CMD_CLEAR_HI = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int POOL_SIZE = 10;
    localparam int PHASES = 10;
    localparam int PLAN_ROWS = 30;

    typedef enum bit {ROW_REQUEST, ROW_LOT} row_kind_t;

    typedef struct packed {
        status_t              status;
        logic [START_W-1:0]   start_slot;
    } outcome_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CMD_W-1:0]     op;
        logic [PLATE_W-1:0]   tag;
        logic [LOT_W-1:0]     want;
        bit                   typed;
        status_t              exp_status;
        logic [START_W-1:0]   exp_start;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_REQUEST, CMD_RELEASE,  16'h0005, 11'd0,    1'b1, ST_ABSENT,    10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0000, 11'd1,    1'b1, ST_PRESENT,   10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0001, 11'd0,    1'b1, ST_NO_ROOM,   10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0001, 11'd1025, 1'b1, ST_NO_ROOM,   10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'hFFFF, 11'd1024, 1'b1, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0002, 11'd1,    1'b1, ST_NO_ROOM,   10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'hFFFF, 11'd1,    1'b1, ST_PRESENT,   10'd0},
        '{ROW_REQUEST, CMD_RELEASE,  16'hFFFF, 11'd2047, 1'b1, ST_RELEASED,  10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h1234, 11'd3,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'hAAAA, 11'd5,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h5555, 11'd2,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_RELEASE,  16'hAAAA, 11'd0,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0F0F, 11'd4,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_RELEASE,  16'h0000, 11'd0,    1'b1, ST_ABSENT,    10'd0},
        '{ROW_LOT,     CMD_ALLOC,    16'h0000, 11'd3,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h5555, 11'd1,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_RELEASE,  16'h1234, 11'd0,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h5555, 11'd3,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_LOT,     CMD_ALLOC,    16'h0000, 11'd0,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0007, 11'd1,    1'b1, ST_NO_ROOM,   10'd0},
        '{ROW_REQUEST, CMD_RELEASE,  16'h5555, 11'd0,    1'b1, ST_ABSENT,    10'd0},
        '{ROW_LOT,     CMD_ALLOC,    16'h0000, 11'd2047, 1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_RELEASE,  16'h5555, 11'd0,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_CLEAR_HI, 16'h0007, 11'd1,    1'b1, ST_CLEARED,   10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h4242, 11'd1023, 1'b1, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h4343, 11'd1,    1'b1, ST_ALLOCATED, 10'd1023},
        '{ROW_REQUEST, CMD_CLEAR,    16'h0000, 11'd0,    1'b1, ST_CLEARED,   10'd0},
        '{ROW_LOT,     CMD_ALLOC,    16'h0000, 11'd1,    1'b0, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0101, 11'd1,    1'b1, ST_ALLOCATED, 10'd0},
        '{ROW_REQUEST, CMD_ALLOC,    16'h0102, 11'd1,    1'b1, ST_NO_ROOM,   10'd0}
    };

    localparam logic [LOT_W-1:0] PHASE_LOT [PHASES] =
        '{11'd16, 11'd40, 11'd1024, 11'd2047, 11'd7, 11'd0, 11'd24, 11'd1, 11'd64, 11'd1536};
    localparam int PHASE_ITEMS [PHASES] = '{32, 32, 32, 28, 28, 8, 32, 12, 32, 28};

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;

    ffca_req_if req_ch ();
    ffca_rsp_if rsp_ch ();
    ffca_cfg_if cfg_ch ();

    first_fit_contiguous_slot_allocator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic [PLATE_W-1:0] owner_model [SLOTS];
    logic [LOT_W-1:0]   lot_model;
    logic [PLATE_W-1:0] tag_pool [POOL_SIZE];
    outcome_t           pending_answers [$];

    int mismatches = 0;
    int requests_sent = 0;
    int lot_writes = 0;
    int stalled_cycles = 0;
    int status_tally [8];

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic outcome_t serve_request(logic [CMD_W-1:0] op, logic [PLATE_W-1:0] tag,
                                               logic [LOT_W-1:0] want);
        outcome_t o;
        int span;
        int run;
        int first;
        bit seen;
        o.status = ST_CLEARED;
        o.start_slot = '0;
        span = (lot_model > SLOTS) ? SLOTS : int'(lot_model);
        seen = 1'b0;
        for (int i = 0; i < span; i++)
        begin
            if (owner_model[i] == tag)
                seen = 1'b1;
        end
        if (op[1])
        begin
            for (int i = 0; i < SLOTS; i++)
                owner_model[i] = '0;
        end
        else if (op == CMD_ALLOC)
        begin
            if (tag == '0 || seen)
                o.status = ST_PRESENT;
            else
            begin
                first = -1;
                run = 0;
                if (want != '0 && want <= span)
                begin
                    for (int i = 0; i < span && first < 0; i++)
                    begin
                        if (owner_model[i] == '0)
                        begin
                            run++;
                            if (run == want)
                                first = i + 1 - int'(want);
                        end
                        else
                            run = 0;
                    end
                end
                if (first < 0)
                    o.status = ST_NO_ROOM;
                else
                begin
                    for (int i = first; i < first + int'(want); i++)
                        owner_model[i] = tag;
                    o.status = ST_ALLOCATED;
                    o.start_slot = START_W'(first);
                end
            end
        end
        else
        begin
            if (tag == '0 || !seen)
                o.status = ST_ABSENT;
            else
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (owner_model[i] == tag)
                        owner_model[i] = '0;
                end
                o.status = ST_RELEASED;
            end
        end
        return o;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] op, input logic [PLATE_W-1:0] tag,
                                input logic [LOT_W-1:0] want, input bit typed,
                                input outcome_t typed_out);
        outcome_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= op;
        req_ch.plate      <= tag;
        req_ch.car_length <= want;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predicted = serve_request(op, tag, want);
        pending_answers.push_back(typed ? typed_out : predicted);
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_lot(input logic [LOT_W-1:0] value);
        wait_until_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.lot_length <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        lot_model = value;
        lot_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(negedge clk)
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 28);

    always @(posedge clk)
    begin
        outcome_t expected;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            status_tally[rsp_ch.status]++;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result beat, status %0d start_slot %0d",
                         $time, rsp_ch.status, rsp_ch.start_slot);
                mismatches++;
            end
            else
            begin
                expected = pending_answers.pop_front();
                if (rsp_ch.status !== expected.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, expected.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.start_slot !== expected.start_slot)
                begin
                    $display("%0t: start_slot expected %0d, got %0d",
                             $time, expected.start_slot, rsp_ch.start_slot);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_answers.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int random_count;
        int span;
        int pick;
        logic [CMD_W-1:0] op;
        logic [PLATE_W-1:0] tag;
        logic [LOT_W-1:0] want;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_ALLOC;
        req_ch.plate      = '0;
        req_ch.car_length = '0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.lot_length = '0;
        random_count      = 0;
        lot_model         = LOT_RESET;
        for (int i = 0; i < SLOTS; i++)
            owner_model[i] = '0;
        for (int i = 0; i < 8; i++)
            status_tally[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = PLATE_W'($urandom_range(1, 65535));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_lot(LOT_RESET);
        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == ROW_LOT)
                write_lot(DIRECTED_PLAN[i].want);
            else
                send_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].tag, DIRECTED_PLAN[i].want,
                             DIRECTED_PLAN[i].typed,
                             '{DIRECTED_PLAN[i].exp_status, DIRECTED_PLAN[i].exp_start});
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_lot(PHASE_LOT[ph]);
            span = (PHASE_LOT[ph] > SLOTS) ? SLOTS : int'(PHASE_LOT[ph]);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                steady = (random_count >= 100 && random_count < 160);
                pick = $urandom_range(0, 99);
                tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
                want = '0;
                if (pick < 55)
                begin
                    op = CMD_ALLOC;
                    want = LOT_W'($urandom_range(1, (span > 3) ? span / 3 : 2));
                end
                else if (pick < 85)
                    op = CMD_RELEASE;
                else if (pick < 89)
                    op = ($urandom_range(0, 1) == 0) ? CMD_CLEAR : CMD_CLEAR_HI;
                else
                begin
                    op = CMD_W'($urandom_range(0, 3));
                    tag = PLATE_W'($urandom_range(0, 65535));
                    want = LOT_W'($urandom_range(0, 2047));
                end
                send_request(op, tag, want, 1'b0, '0);
                random_count++;
            end
        end
        steady = 1'b0;

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests over %0d lot_length settings (zero, one, full, oversized).",
                 requests_sent, lot_writes);
        $display("Results: %0d allocated, %0d rejected, %0d released, %0d absent, %0d cleared.",
                 status_tally[ST_ALLOCATED], status_tally[ST_PRESENT] + status_tally[ST_NO_ROOM],
                 status_tally[ST_RELEASED], status_tally[ST_ABSENT], status_tally[ST_CLEARED]);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
